// File: hdl/x86d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

    // Opcode classes of the decoded subset
    typedef enum logic [2:0] {
        CL_RMREG   = 3'd0,
        CL_IMMRM   = 3'd1,
        CL_IMMREG  = 3'd2,
        CL_ACC     = 3'd3,
        CL_JUMP    = 3'd4,
        CL_UNKNOWN = 3'd5
    } class_t;

    // Mnemonic codes
    localparam logic [4:0] MN_MOV     = 5'd0;
    localparam logic [4:0] MN_ADD     = 5'd1;
    localparam logic [4:0] MN_SUB     = 5'd2;
    localparam logic [4:0] MN_CMP     = 5'd3;
    localparam logic [4:0] MN_JCC     = 5'd4;
    localparam logic [4:0] MN_LOOP    = 5'd20;
    localparam logic [4:0] MN_UNKNOWN = 5'd24;

    // Operand form codes
    localparam logic [2:0] FORM_RMREG  = 3'd0;
    localparam logic [2:0] FORM_IMMRM  = 3'd1;
    localparam logic [2:0] FORM_IMMREG = 3'd2;
    localparam logic [2:0] FORM_ACC    = 3'd3;
    localparam logic [2:0] FORM_JUMP   = 3'd4;

    // Addressing byte mod codes, direct address r/m and arithmetic selectors
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT  = 3'd6;
    localparam logic [2:0] SEL_ADD    = 3'd0;
    localparam logic [2:0] SEL_SUB    = 3'd5;
    localparam logic [2:0] SEL_CMP    = 3'd7;

    // Opcode patterns
    localparam logic [7:0] TOP6_MASK  = 8'hFC;
    localparam logic [7:0] TOP7_MASK  = 8'hFE;
    localparam logic [7:0] OP_MOV_RM  = 8'b1000_1000;
    localparam logic [7:0] OP_ADD_RM  = 8'b0000_0000;
    localparam logic [7:0] OP_SUB_RM  = 8'b0010_1000;
    localparam logic [7:0] OP_CMP_RM  = 8'b0011_1000;
    localparam logic [7:0] OP_MOV_IMM = 8'b1100_0110;
    localparam logic [7:0] OP_GRP_IMM = 8'b1000_0000;
    localparam logic [3:0] OP_MOV_REG = 4'b1011;
    localparam logic [7:0] OP_ADD_ACC = 8'b0000_0100;
    localparam logic [7:0] OP_SUB_ACC = 8'b0010_1100;
    localparam logic [7:0] OP_CMP_ACC = 8'b0011_1100;
    localparam logic [3:0] OP_JCC     = 4'b0111;
    localparam logic [7:0] OP_LOOP    = 8'b1110_0000;

    // Decoded result of one instruction
    typedef struct packed {
        logic [4:0]  mnemonic;
        logic [2:0]  form;
        logic        wide;
        logic        to_reg;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [7:0]  jump_offset;
        logic [2:0]  length;
    } result_t;

    function automatic class_t classify(input logic [7:0] op);
        logic [7:0] top6;
        logic [7:0] top7;
        class_t     cls;
        top6 = op & TOP6_MASK;
        top7 = op & TOP7_MASK;
        if (top6 == OP_MOV_RM || top6 == OP_ADD_RM || top6 == OP_SUB_RM
            || top6 == OP_CMP_RM)
            cls = CL_RMREG;
        else if (top7 == OP_MOV_IMM || top6 == OP_GRP_IMM)
            cls = CL_IMMRM;
        else if (op[7:4] == OP_MOV_REG)
            cls = CL_IMMREG;
        else if (top7 == OP_ADD_ACC || top7 == OP_SUB_ACC || top7 == OP_CMP_ACC)
            cls = CL_ACC;
        else if (op[7:4] == OP_JCC || top6 == OP_LOOP)
            cls = CL_JUMP;
        else
            cls = CL_UNKNOWN;
        return cls;
    endfunction

    function automatic logic has_modrm(input class_t cls);
        return (cls == CL_RMREG) || (cls == CL_IMMRM);
    endfunction

    // Displacement bytes implied by the addressing byte
    function automatic logic [1:0] disp_len(input logic [7:0] m);
        logic [1:0] n;
        case (m[7:6])
            MOD_MEM:    n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            MOD_DISP8:  n = 2'd1;
            MOD_DISP16: n = 2'd2;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    // Data bytes that follow the opcode and addressing bytes
    function automatic logic [1:0] data_len(input logic [7:0] op, input class_t cls);
        logic [1:0] n;
        case (cls)
            CL_IMMRM:
            begin
                if ((op & TOP7_MASK) == OP_MOV_IMM)
                    n = op[0] ? 2'd2 : 2'd1;
                else
                    n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
            end
            CL_IMMREG: n = op[3] ? 2'd2 : 2'd1;
            CL_ACC:    n = op[0] ? 2'd2 : 2'd1;
            CL_JUMP:   n = 2'd1;
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] arith_mnemonic(input logic [2:0] sel);
        logic [4:0] mn;
        case (sel)
            SEL_ADD: mn = MN_ADD;
            SEL_SUB: mn = MN_SUB;
            SEL_CMP: mn = MN_CMP;
            default: mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

endpackage

`default_nettype wire

// File: hdl/x86d_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module x86d_emit (
    input  wire logic [7:0]       op,
    input  wire logic [7:0]       modrm,
    input  wire logic [15:0]      disp,
    input  wire logic [15:0]      data,
    input  wire logic [2:0]       len,
    output x86d_pkg::result_t     result
);

    x86d_pkg::class_t cls;
    logic [1:0]       dl;
    logic [1:0]       tl;
    logic             sign_imm;

    assign cls = x86d_pkg::classify(op);
    assign dl  = x86d_pkg::disp_len(modrm);
    assign tl  = x86d_pkg::data_len(op, cls);

    // Group form with s set widens a single data byte by sign
    assign sign_imm = (cls == x86d_pkg::CL_IMMRM)
                   && ((op & x86d_pkg::TOP7_MASK) != x86d_pkg::OP_MOV_IMM)
                   && op[1] && data[7];

    // Build the decoded fields from the gathered bytes
    always_comb
    begin
        result              = '0;
        result.length       = len;
        if (x86d_pkg::has_modrm(cls))
        begin
            result.mode      = modrm[7:6];
            result.reg_field = modrm[5:3];
            result.rm_field  = modrm[2:0];
            if (dl == 2'd2)
                result.displacement = disp;
            else if (dl == 2'd1)
                result.displacement = {{8{disp[7]}}, disp[7:0]};
        end
        if (cls != x86d_pkg::CL_JUMP && tl != 2'd0)
        begin
            if (tl == 2'd2)
                result.immediate = data;
            else if (sign_imm)
                result.immediate = {8'hFF, data[7:0]};
            else
                result.immediate = {8'h00, data[7:0]};
        end
        case (cls)
            x86d_pkg::CL_RMREG:
            begin
                result.mnemonic = ((op & x86d_pkg::TOP6_MASK) == x86d_pkg::OP_MOV_RM)
                                ? x86d_pkg::MN_MOV : x86d_pkg::arith_mnemonic(op[5:3]);
                result.form     = x86d_pkg::FORM_RMREG;
                result.wide     = op[0];
                result.to_reg   = op[1];
            end
            x86d_pkg::CL_IMMRM:
            begin
                result.mnemonic = ((op & x86d_pkg::TOP7_MASK) == x86d_pkg::OP_MOV_IMM)
                                ? x86d_pkg::MN_MOV : x86d_pkg::arith_mnemonic(modrm[5:3]);
                result.form     = x86d_pkg::FORM_IMMRM;
                result.wide     = op[0];
            end
            x86d_pkg::CL_IMMREG:
            begin
                result.mnemonic  = x86d_pkg::MN_MOV;
                result.form      = x86d_pkg::FORM_IMMREG;
                result.wide      = op[3];
                result.reg_field = op[2:0];
            end
            x86d_pkg::CL_ACC:
            begin
                result.mnemonic = x86d_pkg::arith_mnemonic(op[5:3]);
                result.form     = x86d_pkg::FORM_ACC;
                result.wide     = op[0];
            end
            x86d_pkg::CL_JUMP:
            begin
                if (op[7:4] == x86d_pkg::OP_JCC)
                    result.mnemonic = x86d_pkg::MN_JCC + {1'b0, op[3:0]};
                else
                    result.mnemonic = x86d_pkg::MN_LOOP + {3'b000, op[1:0]};
                result.form        = x86d_pkg::FORM_JUMP;
                result.jump_offset = data[7:0];
            end
            default:
            begin
                result.mnemonic = x86d_pkg::MN_UNKNOWN;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/x86_16_instruction_decoder.sv
// The decoded item is registered and appears in the cycle after the final byte of an instruction is taken.
// One code byte per cycle while in_ready is high; in_ready drops while a result is held and out_ready is low.
// The byte position and length registers track each instruction; one result register holds the item.
// Reset clears the byte position, the expected length, the gathered bytes and the
// output valid; the next byte after reset is taken as an opcode.
`timescale 1ns / 1ps
`default_nettype none

module x86_16_instruction_decoder (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        code_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [4:0]             mnemonic,
    output logic [2:0]             form,
    output logic                   wide,
    output logic                   to_reg,
    output logic [1:0]             mode,
    output logic [2:0]             reg_field,
    output logic [2:0]             rm_field,
    output logic [15:0]            displacement,
    output logic [15:0]            immediate,
    output logic signed [7:0]      jump_offset,
    output logic [2:0]             length
);

    logic [2:0]  pos_reg, pos_next, pos_upd;
    logic [2:0]  need_reg, need_next, need_upd;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] data_reg, data_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        done;

    x86d_pkg::class_t  cls_first;
    x86d_pkg::class_t  cls_held;
    x86d_pkg::result_t result_reg, result_next;

    logic [1:0] dl_held;
    logic [2:0] hdr;
    logic [2:0] idx;
    logic [2:0] data_idx;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cls_first = x86d_pkg::classify(code_byte);
    assign cls_held  = x86d_pkg::classify(op_reg);
    assign dl_held   = x86d_pkg::has_modrm(cls_held) ? x86d_pkg::disp_len(modrm_reg) : 2'd0;
    assign hdr       = x86d_pkg::has_modrm(cls_held) ? 3'd2 : 3'd1;
    assign idx       = pos_reg - hdr;
    assign data_idx  = idx - {1'b0, dl_held};

    // Fold the incoming byte into the partial instruction
    always_comb
    begin
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        data_next  = data_reg;
        pos_upd    = pos_reg;
        need_upd   = need_reg;
        done       = 1'b0;
        if (pos_reg == 3'd0)
        begin
            op_next    = code_byte;
            modrm_next = '0;
            disp_next  = '0;
            data_next  = '0;
            pos_upd    = 3'd1;
            if (x86d_pkg::has_modrm(cls_first))
            begin
                need_upd = 3'd0;
            end
            else
            begin
                need_upd = 3'd1 + {1'b0, x86d_pkg::data_len(code_byte, cls_first)};
                done     = (need_upd <= 3'd1);
            end
        end
        else
        begin
            if (x86d_pkg::has_modrm(cls_held) && pos_reg == 3'd1)
            begin
                modrm_next = code_byte;
                need_upd   = 3'd2 + {1'b0, x86d_pkg::disp_len(code_byte)}
                           + {1'b0, x86d_pkg::data_len(op_reg, cls_held)};
                pos_upd    = 3'd2;
            end
            else
            begin
                if (idx < {1'b0, dl_held})
                begin
                    if (idx[0])
                        disp_next[15:8] = disp_reg[15:8] | code_byte;
                    else
                        disp_next[7:0]  = disp_reg[7:0] | code_byte;
                end
                else
                begin
                    if (data_idx[0])
                        data_next[15:8] = data_reg[15:8] | code_byte;
                    else
                        data_next[7:0]  = data_reg[7:0] | code_byte;
                end
                pos_upd = pos_reg + 3'd1;
            end
            done = (pos_upd >= need_upd);
        end
    end

    // Restart at an opcode once an instruction completes
    assign pos_next  = done ? 3'd0 : pos_upd;
    assign need_next = done ? 3'd0 : need_upd;

    x86d_emit u_emit (
        .op     (op_next),
        .modrm  (modrm_next),
        .disp   (disp_next),
        .data   (data_next),
        .len    (pos_upd),
        .result (result_next)
    );

    // Hold the result until taken, set it on a completed instruction
    always_comb
    begin
        if (accept && done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Advance the instruction state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            need_reg      <= '0;
            op_reg        <= '0;
            modrm_reg     <= '0;
            disp_reg      <= '0;
            data_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pos_reg   <= pos_next;
                need_reg  <= need_next;
                op_reg    <= op_next;
                modrm_reg <= modrm_next;
                disp_reg  <= disp_next;
                data_reg  <= data_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (accept && done)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign mnemonic     = result_reg.mnemonic;
    assign form         = result_reg.form;
    assign wide         = result_reg.wide;
    assign to_reg       = result_reg.to_reg;
    assign mode         = result_reg.mode;
    assign reg_field    = result_reg.reg_field;
    assign rm_field     = result_reg.rm_field;
    assign displacement = result_reg.displacement;
    assign immediate    = result_reg.immediate;
    assign jump_offset  = result_reg.jump_offset;
    assign length       = result_reg.length;

endmodule

`default_nettype wire

// File: bench/x86_16_instruction_decoder_test.sv
`timescale 1ns / 1ps

module x86_16_instruction_decoder_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 200;
    localparam int MAX_REPORTS    = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        code_byte = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [4:0]        mnemonic;
    logic [2:0]        form;
    logic              wide;
    logic              to_reg;
    logic [1:0]        mode;
    logic [2:0]        reg_field;
    logic [2:0]        rm_field;
    logic [15:0]       displacement;
    logic [15:0]       immediate;
    logic signed [7:0] jump_offset;
    logic [2:0]        length;

    // Decoder state as the stream has been taken so far
    logic [2:0]  pos_q = 3'd0;
    logic [2:0]  need_q = 3'd0;
    logic [7:0]  op_q = 8'h00;
    logic [7:0]  modrm_q = 8'h00;
    logic [15:0] disp_q = 16'h0000;
    logic [15:0] data_q = 16'h0000;

    x86d_pkg::result_t pending_decodes[$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      long_stall_req = 1'b0;

    x86_16_instruction_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mnemonic     (mnemonic),
        .form         (form),
        .wide         (wide),
        .to_reg       (to_reg),
        .mode         (mode),
        .reg_field    (reg_field),
        .rm_field     (rm_field),
        .displacement (displacement),
        .immediate    (immediate),
        .jump_offset  (jump_offset),
        .length       (length)
    );

    always #6 clk = ~clk;

    // Opcode class of the first byte
    function automatic x86d_pkg::class_t opcode_kind(input logic [7:0] op);
        x86d_pkg::class_t kind;
        if (op[7:2] == x86d_pkg::OP_MOV_RM[7:2] || op[7:2] == x86d_pkg::OP_ADD_RM[7:2]
            || op[7:2] == x86d_pkg::OP_SUB_RM[7:2] || op[7:2] == x86d_pkg::OP_CMP_RM[7:2])
            kind = x86d_pkg::CL_RMREG;
        else if (op[7:1] == x86d_pkg::OP_MOV_IMM[7:1]
                 || op[7:2] == x86d_pkg::OP_GRP_IMM[7:2])
            kind = x86d_pkg::CL_IMMRM;
        else if (op[7:4] == x86d_pkg::OP_MOV_REG)
            kind = x86d_pkg::CL_IMMREG;
        else if (op[7:1] == x86d_pkg::OP_ADD_ACC[7:1] || op[7:1] == x86d_pkg::OP_SUB_ACC[7:1]
                 || op[7:1] == x86d_pkg::OP_CMP_ACC[7:1])
            kind = x86d_pkg::CL_ACC;
        else if (op[7:4] == x86d_pkg::OP_JCC || op[7:2] == x86d_pkg::OP_LOOP[7:2])
            kind = x86d_pkg::CL_JUMP;
        else
            kind = x86d_pkg::CL_UNKNOWN;
        return kind;
    endfunction

    function automatic bit takes_addr_byte(input x86d_pkg::class_t kind);
        return kind == x86d_pkg::CL_RMREG || kind == x86d_pkg::CL_IMMRM;
    endfunction

    function automatic int addr_disp_bytes(input logic [7:0] m);
        int n;
        case (m[7:6])
            x86d_pkg::MOD_MEM:    n = (m[2:0] == x86d_pkg::RM_DIRECT) ? 2 : 0;
            x86d_pkg::MOD_DISP8:  n = 1;
            x86d_pkg::MOD_DISP16: n = 2;
            default:              n = 0;
        endcase
        return n;
    endfunction

    function automatic int operand_data_bytes(input logic [7:0] op,
                                              input x86d_pkg::class_t kind);
        int n;
        case (kind)
            x86d_pkg::CL_IMMRM:
            begin
                if (op[7:1] == x86d_pkg::OP_MOV_IMM[7:1])
                    n = op[0] ? 2 : 1;
                else
                    n = (!op[1] && op[0]) ? 2 : 1;
            end
            x86d_pkg::CL_IMMREG: n = op[3] ? 2 : 1;
            x86d_pkg::CL_ACC:    n = op[0] ? 2 : 1;
            x86d_pkg::CL_JUMP:   n = 1;
            default:             n = 0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] alu_mnemonic(input logic [2:0] sel);
        logic [4:0] mn;
        case (sel)
            x86d_pkg::SEL_ADD: mn = x86d_pkg::MN_ADD;
            x86d_pkg::SEL_SUB: mn = x86d_pkg::MN_SUB;
            x86d_pkg::SEL_CMP: mn = x86d_pkg::MN_CMP;
            default:           mn = x86d_pkg::MN_UNKNOWN;
        endcase
        return mn;
    endfunction

    function automatic string describe(input x86d_pkg::result_t r);
        return $sformatf({"mn=%0d form=%0d w=%0d d=%0d mod=%0d reg=%0d rm=%0d",
                          " disp=%h imm=%h joff=%h len=%0d"},
                         r.mnemonic, r.form, r.wide, r.to_reg, r.mode, r.reg_field,
                         r.rm_field, r.displacement, r.immediate, r.jump_offset, r.length);
    endfunction

    // Build the decoded fields of the gathered instruction and queue them
    task automatic finish_instruction();
        x86d_pkg::result_t r;
        x86d_pkg::class_t  kind;
        int                dlen;
        int                tlen;
        r = '0;
        kind = opcode_kind(op_q);
        tlen = operand_data_bytes(op_q, kind);
        if (takes_addr_byte(kind))
        begin
            dlen = addr_disp_bytes(modrm_q);
            r.mode = modrm_q[7:6];
            r.reg_field = modrm_q[5:3];
            r.rm_field = modrm_q[2:0];
            if (dlen == 2)
                r.displacement = disp_q;
            else if (dlen == 1)
                r.displacement = {{8{disp_q[7]}}, disp_q[7:0]};
        end
        if (kind != x86d_pkg::CL_JUMP && tlen != 0)
        begin
            if (tlen == 2)
                r.immediate = data_q;
            else if (kind == x86d_pkg::CL_IMMRM && op_q[7:1] != x86d_pkg::OP_MOV_IMM[7:1]
                     && op_q[1])
                r.immediate = {{8{data_q[7]}}, data_q[7:0]};
            else
                r.immediate = {8'h00, data_q[7:0]};
        end
        case (kind)
            x86d_pkg::CL_RMREG:
            begin
                r.mnemonic = (op_q[7:2] == x86d_pkg::OP_MOV_RM[7:2])
                           ? x86d_pkg::MN_MOV : alu_mnemonic(op_q[5:3]);
                r.form = x86d_pkg::FORM_RMREG;
                r.wide = op_q[0];
                r.to_reg = op_q[1];
            end
            x86d_pkg::CL_IMMRM:
            begin
                r.mnemonic = (op_q[7:1] == x86d_pkg::OP_MOV_IMM[7:1])
                           ? x86d_pkg::MN_MOV : alu_mnemonic(modrm_q[5:3]);
                r.form = x86d_pkg::FORM_IMMRM;
                r.wide = op_q[0];
            end
            x86d_pkg::CL_IMMREG:
            begin
                r.mnemonic = x86d_pkg::MN_MOV;
                r.form = x86d_pkg::FORM_IMMREG;
                r.wide = op_q[3];
                r.reg_field = op_q[2:0];
            end
            x86d_pkg::CL_ACC:
            begin
                r.mnemonic = alu_mnemonic(op_q[5:3]);
                r.form = x86d_pkg::FORM_ACC;
                r.wide = op_q[0];
            end
            x86d_pkg::CL_JUMP:
            begin
                r.mnemonic = (op_q[7:4] == x86d_pkg::OP_JCC)
                           ? x86d_pkg::MN_JCC + {1'b0, op_q[3:0]}
                           : x86d_pkg::MN_LOOP + {3'b000, op_q[1:0]};
                r.form = x86d_pkg::FORM_JUMP;
                r.jump_offset = data_q[7:0];
            end
            default: r.mnemonic = x86d_pkg::MN_UNKNOWN;
        endcase
        r.length = pos_q;
        pending_decodes.push_back(r);
        pos_q = 3'd0;
        need_q = 3'd0;
    endtask

    // Advance the decoder state by one code byte
    task automatic decode_code_byte(input logic [7:0] b);
        x86d_pkg::class_t kind;
        int               hdr;
        int               dlen;
        int               idx;
        if (pos_q == 3'd0)
        begin
            op_q = b;
            modrm_q = 8'h00;
            disp_q = 16'h0000;
            data_q = 16'h0000;
            kind = opcode_kind(b);
            pos_q = 3'd1;
            if (takes_addr_byte(kind))
            begin
                need_q = 3'd0;
                return;
            end
            need_q = 3'(1 + operand_data_bytes(b, kind));
        end
        else
        begin
            kind = opcode_kind(op_q);
            if (takes_addr_byte(kind) && pos_q == 3'd1)
            begin
                modrm_q = b;
                need_q = 3'(2 + addr_disp_bytes(b) + operand_data_bytes(op_q, kind));
                pos_q = 3'd2;
            end
            else
            begin
                hdr = takes_addr_byte(kind) ? 2 : 1;
                dlen = takes_addr_byte(kind) ? addr_disp_bytes(modrm_q) : 0;
                idx = int'(pos_q) - hdr;
                if (idx < dlen)
                    disp_q = disp_q | ({8'h00, b} << (8 * (idx % 2)));
                else
                    data_q = data_q | ({8'h00, b} << (8 * ((idx - dlen) % 2)));
                pos_q = pos_q + 3'd1;
            end
        end
        if (pos_q >= need_q)
            finish_instruction();
    endtask

    task automatic note_mismatch(input string what, input x86d_pkg::result_t want,
                                 input x86d_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, what);
            $display("    expected %s", describe(want));
            $display("    actual   %s", describe(got));
        end
    endtask

    // Predict on every byte taken
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            decode_code_byte(code_byte);
    end

    // Compare every item delivered with the oldest prediction
    always @(posedge clk)
    begin
        x86d_pkg::result_t got;
        x86d_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {mnemonic, form, wide, to_reg, mode, reg_field, rm_field,
                   displacement, immediate, jump_offset, length};
            if (pending_decodes.size() == 0)
                note_mismatch("decoded item with no instruction pending", '0, got);
            else
            begin
                want = pending_decodes.pop_front();
                if (got !== want)
                    note_mismatch("decoded fields differ", want, got);
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL x86_16_instruction_decoder");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold on request
    initial
    begin
        int held;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < LONG_STALL; held++)
                    @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one byte, idling at random first, and hold it until taken
    task automatic send_code_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_code_byte(seq[i]);
    endtask

    // Hold the input until every pending instruction has been delivered
    task automatic wait_decodes_drained();
        in_valid <= 1'b0;
        // let the prediction of the last byte land first
        @(posedge clk);
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    // One well-formed instruction with random content, or a random opcode
    task automatic make_instruction(ref logic [7:0] seq[$]);
        logic [7:0]       op;
        x86d_pkg::class_t kind;
        int               total;
        case ($urandom_range(9))
            0, 1:
            begin
                case ($urandom_range(3))
                    0:       op = x86d_pkg::OP_MOV_RM;
                    1:       op = x86d_pkg::OP_ADD_RM;
                    2:       op = x86d_pkg::OP_SUB_RM;
                    default: op = x86d_pkg::OP_CMP_RM;
                endcase
                op = op | 8'($urandom_range(3));
            end
            2, 3: op = $urandom_range(1) ? (x86d_pkg::OP_MOV_IMM | 8'($urandom_range(1)))
                                         : (x86d_pkg::OP_GRP_IMM | 8'($urandom_range(3)));
            4: op = {x86d_pkg::OP_MOV_REG, 4'($urandom_range(15))};
            5:
            begin
                case ($urandom_range(2))
                    0:       op = x86d_pkg::OP_ADD_ACC;
                    1:       op = x86d_pkg::OP_SUB_ACC;
                    default: op = x86d_pkg::OP_CMP_ACC;
                endcase
                op = op | 8'($urandom_range(1));
            end
            6, 7: op = $urandom_range(1) ? {x86d_pkg::OP_JCC, 4'($urandom_range(15))}
                                         : (x86d_pkg::OP_LOOP | 8'($urandom_range(3)));
            default: op = 8'($urandom_range(255));
        endcase
        kind = opcode_kind(op);
        seq.push_back(op);
        total = 1 + operand_data_bytes(op, kind);
        if (takes_addr_byte(kind))
        begin
            seq.push_back(8'($urandom_range(255)));
            total += 1 + addr_disp_bytes(seq[seq.size() - 1]);
        end
        while (seq.size() < total)
            seq.push_back(8'($urandom_range(255)));
    endtask

    // Extremes, every operation and the awkward encodings
    task automatic test_directed_cases();
        logic [7:0] seq[$];
        send_idle_pct = 36;
        recv_idle_pct = 60;
        seq = {8'hFF,                                 // unknown opcode
               8'h00, 8'hC1,                          // add rm-reg, register mode
               8'h8B, 8'h46, 8'hF0,                   // mov, negative byte displacement
               8'h83, 8'h3E, 8'h34, 8'h12, 8'h80,     // cmp direct address, s=1 data
               8'h80, 8'hCB, 8'h12,                   // group with unsupported reg field
               8'hC7, 8'h86, 8'h00, 8'h80, 8'hFF, 8'hFF,  // mov immediate, word displacement
               8'h2D, 8'h00, 8'h80,                   // sub accumulator, word
               8'h7F, 8'h80,                          // jcc, most negative offset
               8'hE3, 8'h7F};                         // jcxz, most positive offset
        send_bytes(seq);
        wait_decodes_drained();
    endtask

    // Random instruction stream at the given idle rates, then a full drain
    task automatic test_random_stream(input int n_bytes, input int s_idle, input int r_idle);
        logic [7:0] seq[$];
        int         sent;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_bytes)
        begin
            seq.delete();
            make_instruction(seq);
            send_bytes(seq);
            sent += seq.size();
        end
        wait_decodes_drained();
    endtask

    // Hold the result side off so that the block fills and stalls its input
    task automatic test_output_stall();
        logic [7:0] seq[$];
        int         n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_stall_req = 1'b1;
        for (n = 0; n < 16; n++)
        begin
            seq.delete();
            make_instruction(seq);
            send_bytes(seq);
        end
        wait_decodes_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_stream(120, 36, 60);
        test_random_stream(120, 60, 36);
        test_output_stall();
        test_random_stream(120, 0, 0);
        // settle past the output register before judging
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("PASS x86_16_instruction_decoder");
        else
            $display("FAIL x86_16_instruction_decoder");
        $finish;
    end

endmodule

// File: sim.f
hdl/x86d_pkg.sv
hdl/x86d_emit.sv
hdl/x86_16_instruction_decoder.sv
bench/x86_16_instruction_decoder_test.sv
